// File: rtl/core/csmacd_pkg.sv
// csmacd_pkg: shared widths, event codes and transaction types of the
// csma/cd backoff station. No dependencies.
package csmacd_pkg;

   // field widths
   localparam int KIND_W   = 3;
   localparam int RAND_W   = 10;
   localparam int SLOT_W   = 10;
   localparam int EXP_W    = 4;
   localparam int TX_W     = 17;
   localparam int WAIT_W   = 32;
   localparam int QUIET_W  = 10;
   localparam int REMAIN_W = 16;

   // reset values and defaults
   localparam logic [SLOT_W-1:0] SLOT_RESET      = 10'd8;
   localparam int                MAX_EXP_DEFAULT = 10;

   // event codes
   localparam logic [KIND_W-1:0] KIND_TICK        = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SET_COLL    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_START_WAIT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_START_TX    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SET_HIT     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_STRETCH_TX  = 3'd5;

   // one input transaction
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              flag_value;
      logic [RAND_W-1:0] rand_bits;
   } req_type;

   // one result transaction
   typedef struct packed {
      logic                collision;
      logic                transmitting;
      logic                backing_off;
      logic                collided_while_waiting;
      logic [REMAIN_W-1:0] tx_remaining;
      logic [QUIET_W-1:0]  no_check_left;
   } rsp_type;

endpackage

// File: rtl/core/csma_cd_backoff_station.sv
// csma_cd_backoff_station: station side of a csma/cd medium with binary
// exponential backoff. Uses csmacd_pkg, csmacd_in_stage, csmacd_core and
// csmacd_out_stage.
//
// Usage: each req_ transaction carries one event (tick, set collision,
// start wait, start transmit, set collision-while-waiting, stretch
// transmit) and yields exactly one rsp_ transaction with the state after
// that event. A transaction is taken when valid is high and stall is low.
// An accepted event sits in the input register, is processed there and its
// result is loaded into the result register, raising rsp_valid. Throughput
// is one event per cycle while the receiver does not stall, set by the
// combinational state update loop (one 10x10 slot multiply for the
// backoff draw).
// When the receiver stalls, the result register holds its transaction and
// the input register holds the next one; req_stall rises once both are
// full. csr_write_data sets the slot length in ticks when csr_write_enable
// is high; write it only while no events are in flight.
// Reset (synchronous, active high) empties both registers, clears the
// station state, sets the exponent to 1 and the slot length to 8 ticks.
module csma_cd_backoff_station #(
   parameter int MAX_EXP = csmacd_pkg::MAX_EXP_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [csmacd_pkg::SLOT_W-1:0]        csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [csmacd_pkg::KIND_W-1:0]        req_kind,
   input  logic                                 req_flag_value,
   input  logic [csmacd_pkg::RAND_W-1:0]        req_rand_bits,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_collision,
   output logic                                 rsp_transmitting,
   output logic                                 rsp_backing_off,
   output logic                                 rsp_collided_while_waiting,
   output logic [csmacd_pkg::REMAIN_W-1:0]      rsp_tx_remaining,
   output logic [csmacd_pkg::QUIET_W-1:0]       rsp_no_check_left
);

   csmacd_pkg::req_type req_item;
   csmacd_pkg::req_type item;
   csmacd_pkg::rsp_type result;
   csmacd_pkg::rsp_type rsp_item;
   logic                item_valid;
   logic                out_ready;
   logic                advance;

   assign req_item.kind       = req_kind;
   assign req_item.flag_value = req_flag_value;
   assign req_item.rand_bits  = req_rand_bits;

   // a held event moves on when the result register can take it
   assign advance = item_valid && out_ready;

   csmacd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   csmacd_core #(
      .MAX_EXP (MAX_EXP)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .advance          (advance),
      .item             (item),
      .result           (result)
   );

   csmacd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_collision              = rsp_item.collision;
   assign rsp_transmitting           = rsp_item.transmitting;
   assign rsp_backing_off            = rsp_item.backing_off;
   assign rsp_collided_while_waiting = rsp_item.collided_while_waiting;
   assign rsp_tx_remaining           = rsp_item.tx_remaining;
   assign rsp_no_check_left          = rsp_item.no_check_left;

   // every processed event shows up as a result
   a_advance_result : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed event produced no result");

   // an accepted event is held in the input register
   a_accept_held : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> item_valid)
      else $error("accepted event lost");

   // a stalled full result register backs up a held event
   a_backpressure : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && item_valid |-> req_stall && !advance)
      else $error("event advanced into a stalled result register");

endmodule

// File: rtl/core/csmacd_in_stage.sv
// csmacd_in_stage: input register of the station, one transaction deep.
// Depends on csmacd_pkg.
module csmacd_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  csmacd_pkg::req_type  req_item,
   input  logic                 advance,
   output logic                 item_valid,
   output csmacd_pkg::req_type  item
);

   logic                valid_ff;
   logic                valid_in;
   csmacd_pkg::req_type item_ff;

   // hold while the held transaction cannot move on
   assign req_stall = valid_ff && !advance;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b0;
      end
      if (req_valid && !req_stall) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: rtl/core/csmacd_core.sv
// csmacd_core: station state, slot register and per-event next-state logic.
// Depends on csmacd_pkg.
module csmacd_core #(
   parameter int MAX_EXP = csmacd_pkg::MAX_EXP_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [csmacd_pkg::SLOT_W-1:0]      csr_write_data,
   input  logic                               advance,
   input  csmacd_pkg::req_type                item,
   output csmacd_pkg::rsp_type                result
);

   localparam int SW = csmacd_pkg::SLOT_W;
   localparam int EW = csmacd_pkg::EXP_W;
   localparam int TW = csmacd_pkg::TX_W;
   localparam int WW = csmacd_pkg::WAIT_W;
   localparam int QW = csmacd_pkg::QUIET_W;
   localparam int RW = csmacd_pkg::RAND_W;
   localparam int PW = MAX_EXP + SW;   // holds 2^MAX_EXP slots

   logic [SW-1:0] slot_ff;
   logic          tx_active_ff, tx_active_in;
   logic          wait_active_ff, wait_active_in;
   logic          collided_ff, collided_in;
   logic          hit_ff, hit_in;
   logic [EW-1:0] exp_ff, exp_in;
   logic [TW-1:0] tx_count_ff, tx_count_in;
   logic [WW-1:0] wait_count_ff, wait_count_in;
   logic [PW-1:0] post_ff, post_in;
   logic [QW-1:0] quiet_ff, quiet_in;

   logic [RW-1:0]    rand_masked;
   logic [SW+RW-1:0] draw_prod;
   logic [PW-1:0]    slot_shift;
   logic [PW-1:0]    post_max;
   logic [SW-1:0]    half_slot;
   logic [SW+EW-1:0] coll_add;
   logic [WW:0]      coll_sum;
   logic [EW-1:0]    exp_bump;

   // backoff draw: random bits kept below the exponent
   always_comb begin
      for (int i = 0; i < RW; i++) begin
         rand_masked[i] = item.rand_bits[i] && (EW'(i) < exp_ff);
      end
   end

   assign draw_prod  = (SW+RW)'(slot_ff) * (SW+RW)'(rand_masked);
   assign slot_shift = PW'(slot_ff) << exp_ff;
   assign half_slot  = slot_ff >> 1;
   assign post_max   = (post_ff > PW'(half_slot)) ? post_ff : PW'(half_slot);
   assign coll_add   = (SW+EW)'(slot_ff) * (SW+EW)'(exp_ff);
   assign coll_sum   = {1'b0, wait_count_ff} + (WW+1)'(coll_add);
   assign exp_bump   = (exp_ff < EW'(MAX_EXP)) ? exp_ff + EW'(1) : exp_ff;

   // next state for one event
   always_comb begin
      tx_active_in   = tx_active_ff;
      wait_active_in = wait_active_ff;
      collided_in    = collided_ff;
      hit_in         = hit_ff;
      exp_in         = exp_ff;
      tx_count_in    = tx_count_ff;
      wait_count_in  = wait_count_ff;
      post_in        = post_ff;
      quiet_in       = quiet_ff;
      unique case (item.kind)
         csmacd_pkg::KIND_TICK: begin
            if (tx_active_ff) begin
               if (tx_count_ff > TW'(1)) begin
                  tx_count_in = tx_count_ff - TW'(1);
               end else begin
                  tx_count_in    = '0;
                  tx_active_in   = 1'b0;
                  wait_active_in = 1'b1;
                  if (collided_ff) begin
                     wait_count_in = WW'(draw_prod);
                     post_in       = slot_shift - PW'(draw_prod);
                     exp_in        = exp_bump;
                  end else begin
                     wait_count_in = WW'(post_max);
                     post_in       = PW'(half_slot);
                     exp_in        = EW'(1);
                  end
               end
            end else if (wait_active_ff) begin
               if (quiet_ff != '0) begin
                  quiet_in = quiet_ff - QW'(1);
               end
               if (wait_count_ff > WW'(1)) begin
                  wait_count_in = wait_count_ff - WW'(1);
               end else if (hit_ff) begin
                  // collision seen while waiting: fixed 2^k-1 slot wait
                  wait_count_in = WW'(slot_shift - PW'(slot_ff));
                  exp_in        = exp_bump;
                  hit_in        = 1'b0;
                  quiet_in      = QW'(slot_ff);
               end else begin
                  wait_count_in  = '0;
                  wait_active_in = 1'b0;
                  exp_in         = EW'(1);
                  if (collided_ff) begin
                     tx_active_in = 1'b1;
                     tx_count_in  = TW'(slot_ff);
                     collided_in  = 1'b0;
                  end
               end
            end
         end
         csmacd_pkg::KIND_SET_COLL: begin
            collided_in = item.flag_value;
            if (item.flag_value && !tx_active_ff) begin
               wait_count_in = coll_sum[WW] ? '1 : coll_sum[WW-1:0];
            end
         end
         csmacd_pkg::KIND_START_WAIT: begin
            wait_active_in = item.flag_value;
            wait_count_in  = WW'(slot_ff);
         end
         csmacd_pkg::KIND_START_TX: begin
            tx_active_in = 1'b1;
            tx_count_in  = TW'(slot_ff);
         end
         csmacd_pkg::KIND_SET_HIT: begin
            hit_in = item.flag_value;
         end
         csmacd_pkg::KIND_STRETCH_TX: begin
            if (tx_count_ff != '1) begin
               tx_count_in = tx_count_ff + TW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_active_ff   <= 1'b0;
         wait_active_ff <= 1'b0;
         collided_ff    <= 1'b0;
         hit_ff         <= 1'b0;
         exp_ff         <= EW'(1);
         tx_count_ff    <= '0;
         wait_count_ff  <= '0;
         post_ff        <= PW'(csmacd_pkg::SLOT_RESET >> 1);
         quiet_ff       <= '0;
      end else if (advance) begin
         tx_active_ff   <= tx_active_in;
         wait_active_ff <= wait_active_in;
         collided_ff    <= collided_in;
         hit_ff         <= hit_in;
         exp_ff         <= exp_in;
         tx_count_ff    <= tx_count_in;
         wait_count_ff  <= wait_count_in;
         post_ff        <= post_in;
         quiet_ff       <= quiet_in;
      end
   end

   // slot length register
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= csmacd_pkg::SLOT_RESET;
      end else if (csr_write_enable) begin
         slot_ff <= csr_write_data;
      end
   end

   // result seen after the event
   always_comb begin
      result.collision              = collided_in;
      result.transmitting           = tx_active_in;
      result.backing_off            = wait_active_in;
      result.collided_while_waiting = hit_in;
      result.tx_remaining           = tx_count_in[TW-1] ? '1 : tx_count_in[TW-2:0];
      result.no_check_left          = quiet_in;
   end

endmodule

// File: rtl/core/csmacd_out_stage.sv
// csmacd_out_stage: result register toward the receiver.
// Depends on csmacd_pkg.
module csmacd_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  csmacd_pkg::rsp_type  result,
   output logic                 ready,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output csmacd_pkg::rsp_type  rsp_item
);

   logic                valid_ff;
   logic                valid_in;
   csmacd_pkg::rsp_type result_ff;

   // free when empty or being taken this cycle
   assign ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = result_ff;

endmodule
